/* rtl/dlpd_pkg.sv */
// shared types and constants for the decimal length prefix deframer
package dlpd_pkg;

  localparam int HEADER_BYTES  = 9;
  localparam int LENGTH_DIGITS = 8;

  localparam int MAX_BUF_W    = 21;
  localparam int HDR_CNT_W    = 4;
  localparam int ACCUM_W      = 27;
  localparam int BODY_CNT_W   = 21;
  localparam int FRAME_LEN_W  = 20;
  localparam int BYTE_W       = 8;

  localparam logic [MAX_BUF_W-1:0] MAX_BUFFER_RESET = 21'd65536;

  // ascii codes used by the length parser
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [0:0] {
    CMD_DATA    = 1'b0,
    CMD_RESTART = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DM_SPACE  = 2'd0,
    DM_SIGN   = 2'd1,
    DM_DIGITS = 2'd2,
    DM_STOP   = 2'd3
  } digit_mode_t;

  typedef enum logic [1:0] {
    ST_HEADER  = 2'd0,
    ST_BODY    = 2'd1,
    ST_ERROR   = 2'd2,
    ST_RESTART = 2'd3
  } status_t;

endpackage

/* rtl/dlpd_in_if.sv */
// input channel: one command and stream byte per item
interface dlpd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [dlpd_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

/* rtl/dlpd_out_if.sv */
// output channel: one result per item
interface dlpd_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [dlpd_pkg::BYTE_W-1:0]      body_byte;
  logic                             last;
  logic [dlpd_pkg::FRAME_LEN_W-1:0] frame_length;

  modport source (output valid, output status, output body_byte, output last,
                  output frame_length, input ready);
  modport sink   (input valid, input status, input body_byte, input last,
                  input frame_length, output ready);
endinterface

/* rtl/decimal_length_prefix_deframer.sv */
// top level: deframer for streams with an ascii decimal length header
//
//   channel   dir  width  contents
//   in_ch     in   1+8    command, data_byte
//   out_ch    out  2+8+1+20  status, body_byte, last, frame_length
//   cfg       in   1+21   cfg_we, cfg_data (max_buffer)
//
// one item per cycle while the output is not stalled: each accepted item
// updates the parser state in the same cycle and its result lands in the
// output register on that edge, so the output appears the cycle after acceptance.
// in_ch.ready is high whenever the output register is empty or being drained.
// rst (synchronous) clears the parser and sets max_buffer to 65536.
module decimal_length_prefix_deframer (
  input  logic                                clk,
  input  logic                                rst,
  dlpd_in_if.sink                             in_ch,
  dlpd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [dlpd_pkg::MAX_BUF_W-1:0]      cfg_data
);

  // configuration and parser state
  logic [dlpd_pkg::MAX_BUF_W-1:0]  max_buffer;
  dlpd_pkg::phase_t                phase, phase_next;
  logic [dlpd_pkg::HDR_CNT_W-1:0]  header_count, header_count_next;
  dlpd_pkg::digit_mode_t           digit_mode, digit_mode_next;
  logic [dlpd_pkg::ACCUM_W-1:0]    length_accum, length_accum_next;
  logic                            minus_seen, minus_seen_next;
  logic [dlpd_pkg::BODY_CNT_W-1:0] body_count, body_count_next;

  // result register
  logic                              out_valid;
  dlpd_pkg::status_t                 out_status;
  logic [dlpd_pkg::BYTE_W-1:0]       out_body;
  logic                              out_last;
  logic [dlpd_pkg::FRAME_LEN_W-1:0]  out_len;

  // combinational result for the item on the input
  dlpd_pkg::status_t                 res_status;
  logic [dlpd_pkg::BYTE_W-1:0]       res_body;
  logic                              res_last;
  logic [dlpd_pkg::FRAME_LEN_W-1:0]  res_len;

  logic                              accept;
  logic [dlpd_pkg::BYTE_W-1:0]       c;
  logic                              is_digit, is_white, is_sign;
  logic                              hdr_overflow, body_overflow;
  logic                              hdr_end, hdr_bad;
  logic [dlpd_pkg::HDR_CNT_W-1:0]    hdr_inc;
  logic [dlpd_pkg::BODY_CNT_W-1:0]   body_inc;
  logic [dlpd_pkg::ACCUM_W-1:0]      accum_times_ten;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign c           = in_ch.data_byte;

  // character classes
  assign is_digit = (c >= dlpd_pkg::CHAR_ZERO) && (c <= dlpd_pkg::CHAR_NINE);
  assign is_white = (c == dlpd_pkg::CHAR_SPACE) ||
                    ((c >= dlpd_pkg::CHAR_TAB) && (c <= dlpd_pkg::CHAR_CR));
  assign is_sign  = (c == dlpd_pkg::CHAR_PLUS) || (c == dlpd_pkg::CHAR_MINUS);

  // limit checks, made before the byte is taken
  assign hdr_inc       = header_count + 1'b1;
  assign body_inc      = body_count + 1'b1;
  assign hdr_overflow  =
    ({{(dlpd_pkg::MAX_BUF_W + 1 - dlpd_pkg::HDR_CNT_W){1'b0}}, header_count} + 22'd1)
    >= {1'b0, max_buffer};
  assign body_overflow = ({1'b0, body_count} + 22'd1) >= {1'b0, max_buffer};

  // accum * 10 as two shifts, wrapped to the accumulator width
  assign accum_times_ten = (length_accum << 3) + (length_accum << 1);

  // header completion check on the updated parser state
  assign hdr_end = hdr_inc >= dlpd_pkg::HDR_CNT_W'(dlpd_pkg::HEADER_BYTES);
  assign hdr_bad = minus_seen_next || (length_accum_next == '0) ||
                   (length_accum_next >= {{(dlpd_pkg::ACCUM_W - dlpd_pkg::MAX_BUF_W){1'b0}},
                                          max_buffer});

  // next state
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    digit_mode_next   = digit_mode;
    length_accum_next = length_accum;
    minus_seen_next   = minus_seen;
    body_count_next   = body_count;
    if (in_ch.command == dlpd_pkg::CMD_RESTART) begin
      phase_next        = dlpd_pkg::PH_HEADER;
      header_count_next = '0;
      digit_mode_next   = dlpd_pkg::DM_SPACE;
      length_accum_next = '0;
      minus_seen_next   = 1'b0;
      body_count_next   = '0;
    end else begin
      unique case (phase)
        dlpd_pkg::PH_HEADER: begin
          if (hdr_overflow) begin
            phase_next = dlpd_pkg::PH_ERROR;
          end else begin
            // strtoul-style digit parsing over the length field
            if (header_count < dlpd_pkg::HDR_CNT_W'(dlpd_pkg::LENGTH_DIGITS)) begin
              if (digit_mode == dlpd_pkg::DM_SPACE && is_white) begin
                digit_mode_next = digit_mode;
              end else if (digit_mode == dlpd_pkg::DM_SPACE && is_sign) begin
                if (c == dlpd_pkg::CHAR_MINUS) begin
                  minus_seen_next = 1'b1;
                end
                digit_mode_next = dlpd_pkg::DM_SIGN;
              end else if (digit_mode == dlpd_pkg::DM_STOP) begin
                digit_mode_next = digit_mode;
              end else if (is_digit) begin
                length_accum_next = accum_times_ten +
                  {{(dlpd_pkg::ACCUM_W - 4){1'b0}}, c[3:0]};
                digit_mode_next   = dlpd_pkg::DM_DIGITS;
              end else begin
                digit_mode_next = dlpd_pkg::DM_STOP;
              end
            end
            header_count_next = hdr_inc;
            if (hdr_end) begin
              phase_next = hdr_bad ? dlpd_pkg::PH_ERROR : dlpd_pkg::PH_BODY;
            end
          end
        end
        dlpd_pkg::PH_BODY: begin
          if (body_overflow) begin
            phase_next = dlpd_pkg::PH_ERROR;
          end else begin
            body_count_next = body_inc;
            if ({{(dlpd_pkg::ACCUM_W - dlpd_pkg::BODY_CNT_W){1'b0}}, body_inc}
                >= length_accum) begin
              phase_next = dlpd_pkg::PH_DONE;
            end
          end
        end
        default: begin
          phase_next = dlpd_pkg::PH_ERROR;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res_status = dlpd_pkg::ST_ERROR;
    res_body   = '0;
    res_last   = 1'b0;
    if (in_ch.command == dlpd_pkg::CMD_RESTART) begin
      res_status = dlpd_pkg::ST_RESTART;
    end else begin
      unique case (phase)
        dlpd_pkg::PH_HEADER: begin
          if (!hdr_overflow && !(hdr_end && hdr_bad)) begin
            res_status = dlpd_pkg::ST_HEADER;
          end
        end
        dlpd_pkg::PH_BODY: begin
          if (!body_overflow) begin
            res_status = dlpd_pkg::ST_BODY;
            res_body   = c;
            res_last   = (phase_next == dlpd_pkg::PH_DONE);
          end
        end
        default: begin
          res_status = dlpd_pkg::ST_ERROR;
        end
      endcase
    end
    res_len = (phase_next == dlpd_pkg::PH_BODY || phase_next == dlpd_pkg::PH_DONE) ?
              length_accum_next[dlpd_pkg::FRAME_LEN_W-1:0] : '0;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_buffer <= dlpd_pkg::MAX_BUFFER_RESET;
    end else if (cfg_we) begin
      max_buffer <= cfg_data;
    end
  end

  // parser state update on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dlpd_pkg::PH_HEADER;
      header_count <= '0;
      digit_mode   <= dlpd_pkg::DM_SPACE;
      length_accum <= '0;
      minus_seen   <= 1'b0;
      body_count   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      digit_mode   <= digit_mode_next;
      length_accum <= length_accum_next;
      minus_seen   <= minus_seen_next;
      body_count   <= body_count_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= res_status;
      out_body   <= res_body;
      out_last   <= res_last;
      out_len    <= res_len;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.body_byte    = out_body;
  assign out_ch.last         = out_last;
  assign out_ch.frame_length = out_len;

  // a restart item always leaves a clean header state
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.command == dlpd_pkg::CMD_RESTART |=>
      phase == dlpd_pkg::PH_HEADER && header_count == '0 && body_count == '0)
    else $error("restart did not clear parser state");

  // body phase only follows a good header and never runs past the length
  a_body_sane: assert property (@(posedge clk) disable iff (rst)
    phase == dlpd_pkg::PH_BODY |->
      !minus_seen && length_accum != '0 &&
      {{(dlpd_pkg::ACCUM_W - dlpd_pkg::BODY_CNT_W){1'b0}}, body_count} < length_accum)
    else $error("body phase with bad length or count");

  // only body results carry a byte or a last flag
  a_non_body_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != dlpd_pkg::ST_BODY |-> !out_last && out_body == '0)
    else $error("non-body result carries body data");

  // the last flag moves the parser to done
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    accept && res_last |=> phase == dlpd_pkg::PH_DONE)
    else $error("last body byte did not complete the frame");

endmodule

/* sim/decimal_length_prefix_deframer_tb.sv */
// testbench for the decimal length prefix deframer: predictor, stimulus and checks
`timescale 1ns / 100ps

module decimal_length_prefix_deframer_tb;

  localparam int ITEM_TARGET = 1550;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_SETTINGS = 6;

  // one expected result of the deframer
  typedef struct packed {
    dlpd_pkg::status_t                status;
    logic [dlpd_pkg::BYTE_W-1:0]      body_byte;
    logic                             last;
    logic [dlpd_pkg::FRAME_LEN_W-1:0] frame_length;
  } frame_result_t;

  // frame parser mirror and queue of expected results
  class frame_scoreboard;
    logic [dlpd_pkg::MAX_BUF_W-1:0]  max_buffer;
    dlpd_pkg::phase_t                phase;
    logic [dlpd_pkg::HDR_CNT_W-1:0]  header_count;
    dlpd_pkg::digit_mode_t           digit_mode;
    logic [dlpd_pkg::ACCUM_W-1:0]    length_value;
    bit                              minus_seen;
    logic [dlpd_pkg::BODY_CNT_W-1:0] body_count;
    frame_result_t                   expected_q[$];
    int                              mismatches;
    int                              checked;
    int                              frames_done;
    int                              status_count[4];

    function new();
      max_buffer = dlpd_pkg::MAX_BUFFER_RESET;
      restart_parser();
    endfunction

    function void restart_parser();
      phase        = dlpd_pkg::PH_HEADER;
      header_count = '0;
      digit_mode   = dlpd_pkg::DM_SPACE;
      length_value = '0;
      minus_seen   = 1'b0;
      body_count   = '0;
    endfunction

    task report(input string msg);
      if (mismatches < 50) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // works out the result of one accepted item
    function void note_input(input dlpd_pkg::command_t cmd,
                             input logic [dlpd_pkg::BYTE_W-1:0] c);
      frame_result_t res;
      bit is_digit;
      bit is_space;
      bit is_sign;
      is_digit         = (c >= dlpd_pkg::CHAR_ZERO) && (c <= dlpd_pkg::CHAR_NINE);
      is_space         = (c == dlpd_pkg::CHAR_SPACE) ||
                         ((c >= dlpd_pkg::CHAR_TAB) && (c <= dlpd_pkg::CHAR_CR));
      is_sign          = (c == dlpd_pkg::CHAR_PLUS) || (c == dlpd_pkg::CHAR_MINUS);
      res.status       = dlpd_pkg::ST_ERROR;
      res.body_byte    = '0;
      res.last         = 1'b0;
      res.frame_length = '0;
      if (cmd == dlpd_pkg::CMD_RESTART) begin
        restart_parser();
        res.status = dlpd_pkg::ST_RESTART;
      end else begin
        case (phase)
          dlpd_pkg::PH_HEADER: begin
            if (32'(header_count) + 32'd1 >= 32'(max_buffer)) begin
              phase = dlpd_pkg::PH_ERROR;
            end else begin
              // strtoul-style parse over the length characters
              if (32'(header_count) < dlpd_pkg::LENGTH_DIGITS) begin
                if (digit_mode == dlpd_pkg::DM_SPACE && is_space) begin
                  // leading white space skipped
                end else if (digit_mode == dlpd_pkg::DM_SPACE && is_sign) begin
                  if (c == dlpd_pkg::CHAR_MINUS) minus_seen = 1'b1;
                  digit_mode = dlpd_pkg::DM_SIGN;
                end else if (digit_mode != dlpd_pkg::DM_STOP) begin
                  if (is_digit) begin
                    length_value = dlpd_pkg::ACCUM_W'(32'(length_value) * 10 +
                                                      32'(c - dlpd_pkg::CHAR_ZERO));
                    digit_mode   = dlpd_pkg::DM_DIGITS;
                  end else begin
                    digit_mode = dlpd_pkg::DM_STOP;
                  end
                end
              end
              header_count = header_count + 1'b1;
              res.status   = dlpd_pkg::ST_HEADER;
              // header complete: validate the length
              if (32'(header_count) >= dlpd_pkg::HEADER_BYTES) begin
                if (minus_seen || length_value == '0 ||
                    32'(length_value) >= 32'(max_buffer)) begin
                  phase      = dlpd_pkg::PH_ERROR;
                  res.status = dlpd_pkg::ST_ERROR;
                end else begin
                  phase = dlpd_pkg::PH_BODY;
                end
              end
            end
          end
          dlpd_pkg::PH_BODY: begin
            if (32'(body_count) + 32'd1 >= 32'(max_buffer)) begin
              phase = dlpd_pkg::PH_ERROR;
            end else begin
              body_count    = body_count + 1'b1;
              res.status    = dlpd_pkg::ST_BODY;
              res.body_byte = c;
              if (32'(body_count) >= 32'(length_value)) begin
                res.last = 1'b1;
                phase    = dlpd_pkg::PH_DONE;
              end
            end
          end
          default: phase = dlpd_pkg::PH_ERROR;
        endcase
      end
      if (phase == dlpd_pkg::PH_BODY || phase == dlpd_pkg::PH_DONE)
        res.frame_length = length_value[dlpd_pkg::FRAME_LEN_W-1:0];
      expected_q.push_back(res);
    endfunction

    // compares one accepted result with the oldest expectation
    task check_result(input logic [1:0] status, input logic [dlpd_pkg::BYTE_W-1:0] body_byte,
                      input logic last,
                      input logic [dlpd_pkg::FRAME_LEN_W-1:0] frame_length);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no item waiting, status %0d", status));
      end else begin
        want = expected_q.pop_front();
        if (status !== want.status)
          report($sformatf("result %0d status %0d, want %0d", checked, status, want.status));
        if (body_byte !== want.body_byte)
          report($sformatf("result %0d body_byte %02h, want %02h", checked, body_byte,
                           want.body_byte));
        if (last !== want.last)
          report($sformatf("result %0d last %0d, want %0d", checked, last, want.last));
        if (frame_length !== want.frame_length)
          report($sformatf("result %0d frame_length %0d, want %0d", checked, frame_length,
                           want.frame_length));
        status_count[want.status]++;
        if (want.last) frames_done++;
        checked++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [dlpd_pkg::MAX_BUF_W-1:0] cfg_data;
  logic sink_ready = 1'b0;
  bit idle_on = 1'b1;
  bit quiet_tail = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int p;
  logic [dlpd_pkg::MAX_BUF_W-1:0] settings[NUM_SETTINGS];
  frame_scoreboard sb = new();

  dlpd_in_if  in_ch();
  dlpd_out_if out_ch();

  assign out_ch.ready = sink_ready;

  decimal_length_prefix_deframer DUT (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // cycle limit and result monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end else if (!rst && out_ch.valid && sink_ready) begin
      sb.check_result(out_ch.status, out_ch.body_byte, out_ch.last, out_ch.frame_length);
    end
  end

  // offers one item, with an optional gap before it, and waits for acceptance
  task automatic send_item(input dlpd_pkg::command_t cmd,
                           input logic [dlpd_pkg::BYTE_W-1:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(dlpd_pkg::CMD_DATA, s[i]);
  endtask

  task automatic send_random_bytes(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_item(dlpd_pkg::CMD_DATA, dlpd_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // waits until every expected result has come back
  task automatic drain_results(input int extra);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_max_buffer(input logic [dlpd_pkg::MAX_BUF_W-1:0] v);
    drain_results(2);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_buffer = v;
  endtask

  // header: white space, optional sign, zero padding, digits, then filler
  task automatic send_header(input int len, input int sign_mode, input bit no_digits);
    string digits;
    int pad, lead, zeros, n, i;
    logic [dlpd_pkg::BYTE_W-1:0] c;
    logic [dlpd_pkg::BYTE_W-1:0] hdr[dlpd_pkg::LENGTH_DIGITS];
    digits = no_digits ? "" : $sformatf("%0d", len);
    pad    = dlpd_pkg::LENGTH_DIGITS - digits.len() - ((sign_mode != 0) ? 1 : 0);
    lead   = $urandom_range(0, pad);
    zeros  = no_digits ? 0 : $urandom_range(0, pad - lead);
    n      = 0;
    for (i = 0; i < lead; i++) begin
      hdr[n] = ($urandom_range(0, 5) == 0) ? dlpd_pkg::CHAR_SPACE :
               dlpd_pkg::BYTE_W'(32'(dlpd_pkg::CHAR_TAB) + $urandom_range(0, 4));
      n++;
    end
    if (sign_mode != 0) begin
      hdr[n] = (sign_mode == 1) ? dlpd_pkg::CHAR_PLUS : dlpd_pkg::CHAR_MINUS;
      n++;
    end
    for (i = 0; i < zeros; i++) begin
      hdr[n] = dlpd_pkg::CHAR_ZERO;
      n++;
    end
    for (i = 0; i < digits.len(); i++) begin
      hdr[n] = digits[i];
      n++;
    end
    // a non-digit ends the number, anything may follow it
    if (n < dlpd_pkg::LENGTH_DIGITS) begin
      do c = dlpd_pkg::BYTE_W'($urandom_range(0, 255));
      while (c >= dlpd_pkg::CHAR_ZERO && c <= dlpd_pkg::CHAR_NINE);
      hdr[n] = c;
      n++;
    end
    while (n < dlpd_pkg::LENGTH_DIGITS) begin
      hdr[n] = dlpd_pkg::BYTE_W'($urandom_range(0, 255));
      n++;
    end
    for (i = 0; i < dlpd_pkg::LENGTH_DIGITS; i++) send_item(dlpd_pkg::CMD_DATA, hdr[i]);
    send_random_bytes(dlpd_pkg::HEADER_BYTES - dlpd_pkg::LENGTH_DIGITS);
  endtask

  // one random frame, mostly well formed, closed by a restart
  task automatic send_random_frame();
    int kind, len, cap;
    cap     = int'(sb.max_buffer) - 1;
    kind    = $urandom_range(0, 99);
    idle_on = quiet_tail ? 1'b0 : ($urandom_range(0, 3) != 0);
    if (kind < 70) begin
      if ($urandom_range(0, 19) == 0) len = $urandom_range(1, (cap < 300) ? cap : 300);
      else len = $urandom_range(1, (cap < 40) ? cap : 40);
      send_header(len, $urandom_range(0, 1), 1'b0);
      if ($urandom_range(0, 19) == 0) begin
        // restart part way through the body
        send_random_bytes($urandom_range(0, len - 1));
      end else begin
        send_random_bytes(len);
        if ($urandom_range(0, 2) == 0) send_random_bytes($urandom_range(1, 2));
      end
    end else if (kind < 78) begin
      // length above capacity, at or above max_buffer
      len = cap + 1 + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 5000));
      send_header(len, $urandom_range(0, 1), 1'b0);
      send_random_bytes($urandom_range(0, 2));
    end else if (kind < 85) begin
      // zero length or no digits at all
      send_header(0, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
      send_random_bytes($urandom_range(0, 2));
    end else if (kind < 92) begin
      // negative length
      send_header($urandom_range(0, 200), 2, 1'b0);
      send_random_bytes($urandom_range(0, 2));
    end else begin
      send_random_bytes($urandom_range(1, 20));
    end
    send_item(dlpd_pkg::CMD_RESTART, dlpd_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.command   <= dlpd_pkg::CMD_DATA;
    in_ch.data_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    settings = '{dlpd_pkg::MAX_BUFFER_RESET, 21'd16, 21'd1048576,
                 21'($urandom_range(16, 1048576)), 21'd17, 21'd1000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tab, plus sign, zero padding: the length field parses to zero, so the header errors; bytes 00 and FF follow
    send_text("\t+0000002:");
    send_item(dlpd_pkg::CMD_DATA, 8'h00);
    send_item(dlpd_pkg::CMD_DATA, 8'hFF);
    // further bytes in the error phase
    send_text("AB");
    send_item(dlpd_pkg::CMD_RESTART, 8'hFF);
    // negative length
    send_text("  -7     ");
    send_item(dlpd_pkg::CMD_RESTART, 8'h00);

    for (p = 0; p < NUM_SETTINGS; p++) begin
      if (p != 0) write_max_buffer(settings[p]);
      quiet_tail = (p == NUM_SETTINGS - 1);
      if (quiet_tail) idle_on = 1'b0;
      // capacity lowered mid-body so the next body item overflows
      if (settings[p] >= 21'd1000) begin
        send_header(40, 0, 1'b0);
        send_random_bytes(20);
        write_max_buffer(21'd16);
        send_random_bytes(2);
        send_item(dlpd_pkg::CMD_RESTART, dlpd_pkg::BYTE_W'($urandom_range(0, 255)));
        write_max_buffer(settings[p]);
      end
      while (items_sent < (p + 1) * ITEM_TARGET / NUM_SETTINGS) send_random_frame();
    end

    drain_results(5);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
    $display("%0d items sent over %0d capacity settings, %0d results checked",
             items_sent, NUM_SETTINGS, sb.checked);
    $display("results: %0d header, %0d body, %0d error, %0d restart; %0d frames completed",
             sb.status_count[dlpd_pkg::ST_HEADER], sb.status_count[dlpd_pkg::ST_BODY],
             sb.status_count[dlpd_pkg::ST_ERROR], sb.status_count[dlpd_pkg::ST_RESTART],
             sb.frames_done);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
